@@ hdl/bucketed_priority_queue_top_defines.svh @@
// Assertion macros for the bucketed priority queue.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BUCKETED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define BUCKETED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define BPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define BPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bpq_pkg.sv @@
// Package for the bucketed priority queue: sizes, field widths, codes
// and the level priority encoder. No dependencies.
package bpq_pkg;

  localparam int CAPACITY    = 256;
  localparam int LEVELS      = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LVL_W  = $clog2(LEVELS);

  // Fixed widths of the channel fields
  localparam int ELEM_FW   = 32;
  localparam int LEVEL_FW  = 4;
  localparam int COUNT_FW  = 9;
  localparam int STATUS_FW = 2;
  localparam int CFG_W     = 4;

  localparam logic [CFG_W-1:0] LOWEST_LEVEL_RST = 4'd15;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [STATUS_FW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef logic [LEVELS-1:0] mask_t;

  // Most urgent set bit; 0 when none is set.
  function automatic logic [LVL_W-1:0] first_level(input mask_t m);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (m[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

endpackage

@@ hdl/bpq_in_if.sv @@
// Input channel of the bucketed priority queue: valid/ready plus request.
// Depends on bpq_pkg.
interface bpq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [bpq_pkg::ELEM_FW-1:0]   elem_value;
  logic [bpq_pkg::LEVEL_FW-1:0]  level;

  modport source(output valid, op, elem_value, level, input ready);
  modport sink(input valid, op, elem_value, level, output ready);
endinterface

@@ hdl/bpq_out_if.sv @@
// Result channel of the bucketed priority queue: valid/ready plus report.
// Depends on bpq_pkg.
interface bpq_out_if;
  logic                           valid;
  logic                           ready;
  logic [bpq_pkg::ELEM_FW-1:0]    head_value;
  logic [bpq_pkg::LEVEL_FW-1:0]   head_level;
  logic [bpq_pkg::COUNT_FW-1:0]   count;
  logic                           is_empty;
  logic [bpq_pkg::STATUS_FW-1:0]  status;

  modport source(output valid, head_value, head_level, count, is_empty, status,
                 input ready);
  modport sink(input valid, head_value, head_level, count, is_empty, status,
               output ready);
endinterface

@@ hdl/bucketed_priority_queue_top.sv @@
// Bucketed priority queue: one FIFO per level as linked lists in shared RAMs.
// Enqueue and rejected requests pass IDLE then MEM; a dequeue also passes VAL
// (link read, then head value read). One request in flight: a new request is
// taken only in IDLE, after the read/modify/write pass over the RAMs is done.
// Reset (rst_n, synchronous): queue empty, all slots free, lowest_level 15.
// No clearing pass: a low-water mark hands out unused slots, freed ones are linked.
`include "bucketed_priority_queue_top_defines.svh"

module bucketed_priority_queue_top (
  input  logic                       clk,
  input  logic                       rst_n,
  bpq_in_if.sink                     in_ch,
  bpq_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [bpq_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int SLOT_W = bpq_pkg::SLOT_W;
  localparam int CNT_W  = bpq_pkg::CNT_W;
  localparam int LVL_W  = bpq_pkg::LVL_W;
  localparam int VW     = bpq_pkg::VALUE_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MEM  = 4'b0010,
    S_VAL  = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [bpq_pkg::CFG_W-1:0]    lowest_r;
  bpq_pkg::mask_t               mask_r, mask_nxt;
  logic [CNT_W-1:0]             free_top_r, free_top_nxt;
  logic [CNT_W-1:0]             low_r, low_nxt;
  logic [SLOT_W-1:0]            free_head_r, free_head_nxt;
  logic [SLOT_W-1:0]            head_r [bpq_pkg::LEVELS];
  logic [SLOT_W-1:0]            tail_r [bpq_pkg::LEVELS];
  logic [SLOT_W-1:0]            head_nxt [bpq_pkg::LEVELS];
  logic [SLOT_W-1:0]            tail_nxt [bpq_pkg::LEVELS];

  // Request captured at transfer
  logic                         op_r;
  logic [VW-1:0]                val_r;
  logic [bpq_pkg::LEVEL_FW-1:0] lvl_r;
  bpq_pkg::status_t             status_r, status_acc;

  // Result waiting for the output register
  logic [VW-1:0]                res_value_r;
  logic [LVL_W-1:0]             res_level_r;
  bpq_pkg::status_t             res_status_r;

  logic                         out_valid_r;
  logic [VW-1:0]                out_value_r;
  logic [LVL_W-1:0]             out_level_r;
  logic [CNT_W-1:0]             out_count_r;
  bpq_pkg::status_t             out_status_r;

  // RAM ports
  logic              vram_we, vram_re, lram_we, lram_re;
  logic [SLOT_W-1:0] vram_addr, lram_addr, lram_wdata;
  logic [SLOT_W-1:0] lram_rd;
  logic [VW-1:0]     vram_rd;

  logic              in_ready, in_accept, out_free;
  logic [LVL_W-1:0]  lold, lnew, lvl_i;
  logic              any;
  logic [SLOT_W-1:0] slot;
  logic              fin_valid;
  logic [VW-1:0]     fin_value;
  logic [LVL_W-1:0]  fin_level;
  bpq_pkg::status_t  fin_status;
  logic              all_free, rpt_empty, rpt_clear;

  bpq_ram #(.DEPTH(bpq_pkg::CAPACITY), .WIDTH(VW)) u_value_ram (
    .clk(clk), .we(vram_we), .re(vram_re), .addr(vram_addr),
    .wdata(val_r), .rdata(vram_rd)
  );

  bpq_ram #(.DEPTH(bpq_pkg::CAPACITY), .WIDTH(SLOT_W)) u_link_ram (
    .clk(clk), .we(lram_we), .re(lram_re), .addr(lram_addr),
    .wdata(lram_wdata), .rdata(lram_rd)
  );

  assign in_ready     = (state_r == S_IDLE);
  assign in_ch.ready  = in_ready;
  assign in_accept    = in_ch.valid && in_ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  // Early status, from state that holds until this request completes
  always_comb begin
    status_acc = bpq_pkg::ST_OK;
    if (in_ch.op == bpq_pkg::OP_ENQ) begin
      if (in_ch.level > lowest_r || 32'(in_ch.level) >= bpq_pkg::LEVELS)
        status_acc = bpq_pkg::ST_RANGE;
      else if (free_top_r == '0)
        status_acc = bpq_pkg::ST_FULL;
    end else if (mask_r == '0) begin
      status_acc = bpq_pkg::ST_EMPTY;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    free_top_nxt  = free_top_r;
    low_nxt       = low_r;
    free_head_nxt = free_head_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    vram_we = 1'b0; vram_re = 1'b0; vram_addr = '0;
    lram_we = 1'b0; lram_re = 1'b0; lram_addr = '0; lram_wdata = '0;
    fin_valid  = 1'b0;
    fin_value  = '0;
    fin_level  = '0;
    fin_status = status_r;
    slot  = '0;
    lold  = bpq_pkg::first_level(mask_r);
    any   = |mask_r;
    lvl_i = LVL_W'(lvl_r);
    lnew  = '0;

    case (state_r)
      S_IDLE: begin
        // Read current head value, and the link of the queue head or the free list head
        if (in_accept) begin
          vram_re   = 1'b1;
          vram_addr = head_r[lold];
          lram_re   = 1'b1;
          lram_addr = (in_ch.op == bpq_pkg::OP_ENQ) ? free_head_r : head_r[lold];
          state_nxt = S_MEM;
        end
      end
      S_MEM: begin
        if (status_r != bpq_pkg::ST_OK) begin
          fin_valid = 1'b1;
          fin_value = any ? vram_rd : '0;
          fin_level = any ? lold : '0;
        end else if (op_r == bpq_pkg::OP_ENQ) begin
          // Slots below the low mark were never handed out; freed slots form a list
          if (free_top_r == low_r) begin
            slot    = SLOT_W'(low_r - CNT_W'(1));
            low_nxt = low_r - CNT_W'(1);
          end else begin
            slot          = free_head_r;
            free_head_nxt = lram_rd;
          end
          vram_we   = 1'b1;
          vram_addr = slot;
          if (mask_r[lvl_i]) begin
            lram_we    = 1'b1;
            lram_addr  = tail_r[lvl_i];
            lram_wdata = slot;
          end else begin
            head_nxt[lvl_i] = slot;
          end
          tail_nxt[lvl_i] = slot;
          mask_nxt[lvl_i] = 1'b1;
          free_top_nxt    = free_top_r - CNT_W'(1);
          fin_valid = 1'b1;
          if (!any || lvl_i < lold) begin
            fin_value = val_r;
            fin_level = lvl_i;
          end else begin
            fin_value = vram_rd;
            fin_level = lold;
          end
        end else begin
          slot = head_r[lold];
          if (slot == tail_r[lold]) mask_nxt[lold] = 1'b0;
          else head_nxt[lold] = lram_rd;
          lram_we       = 1'b1;
          lram_addr     = slot;
          lram_wdata    = free_head_r;
          free_head_nxt = slot;
          free_top_nxt  = free_top_r + CNT_W'(1);
          lnew      = bpq_pkg::first_level(mask_nxt);
          vram_re   = 1'b1;
          vram_addr = head_nxt[lnew];
          state_nxt = S_VAL;
        end
      end
      S_VAL: begin
        fin_valid  = 1'b1;
        fin_value  = any ? vram_rd : '0;
        fin_level  = any ? lold : '0;
        fin_status = bpq_pkg::ST_OK;
      end
      S_HOLD: begin
        fin_valid  = 1'b1;
        fin_value  = res_value_r;
        fin_level  = res_level_r;
        fin_status = res_status_r;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (fin_valid) state_nxt = out_free ? S_IDLE : S_HOLD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lowest_r    <= bpq_pkg::LOWEST_LEVEL_RST;
      mask_r      <= '0;
      free_top_r  <= CNT_W'(bpq_pkg::CAPACITY);
      low_r       <= CNT_W'(bpq_pkg::CAPACITY);
      free_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      free_top_r  <= free_top_nxt;
      low_r       <= low_nxt;
      free_head_r <= free_head_nxt;
      if (cfg_we) lowest_r <= cfg_wdata;
      if (fin_valid && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)     out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    if (in_accept) begin
      op_r     <= in_ch.op;
      val_r    <= in_ch.elem_value[VW-1:0];
      lvl_r    <= in_ch.level;
      status_r <= status_acc;
    end
    if (fin_valid && !out_free) begin
      res_value_r  <= fin_value;
      res_level_r  <= fin_level;
      res_status_r <= fin_status;
    end
    if (fin_valid && out_free) begin
      out_value_r  <= fin_value;
      out_level_r  <= fin_level;
      out_count_r  <= CNT_W'(bpq_pkg::CAPACITY) - free_top_nxt;
      out_status_r <= fin_status;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.head_value = bpq_pkg::ELEM_FW'(out_value_r);
  assign out_ch.head_level = bpq_pkg::LEVEL_FW'(out_level_r);
  assign out_ch.count      = bpq_pkg::COUNT_FW'(out_count_r);
  assign out_ch.is_empty   = (out_count_r == '0);
  assign out_ch.status     = out_status_r;

  assign all_free  = (free_top_r == CNT_W'(bpq_pkg::CAPACITY));
  assign rpt_empty = out_valid_r && (out_count_r == '0);
  assign rpt_clear = (out_value_r == '0) && (out_level_r == '0);

  `BPQ_ASSERT_NEXT(a_accept_to_mem, in_accept, state_r == S_MEM, "transfer did not start RAM pass")
  `BPQ_ASSERT_NOW(a_low_mark, 1'b1, low_r <= free_top_r, "free stack low mark above top")
  `BPQ_ASSERT_NOW(a_mask_count, 1'b1, all_free == (mask_r == '0), "level mask disagrees with count")
  `BPQ_ASSERT_NOW(a_empty_report, rpt_empty, rpt_clear, "empty queue reports a head")

endmodule

@@ hdl/bpq_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module bpq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end

endmodule
